[rtl/brb_pkg.sv]
// Shared types, codes and channel layout constants for the byte ring buffer.
package brb_pkg;

  // Byte lanes carried by one transfer and the width of a lane number
  localparam int DATA_BYTES = 8;
  localparam int LANE_W     = 4;

  // Channel widths
  localparam int IN_TDATA_W  = 72;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 96;
  localparam int OUT_TUSER_W = 2;
  localparam int CFG_W       = 13;

  // Configuration register indexes
  localparam logic CFG_RING_CAP  = 1'b0;
  localparam logic CFG_FLAG_SIZE = 1'b1;

  // Operation codes carried in the input tuser
  typedef enum logic [2:0] {
    OP_WRITE   = 3'd0,
    OP_READ    = 3'd1,
    OP_PEEK    = 3'd2,
    OP_FLAG_WR = 3'd3,
    OP_FLAG_RD = 3'd4
  } brb_op_t;

  // Result status codes carried in the output tuser
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_SPACE  = 2'd1,
    ST_RANGE_ERR = 2'd2
  } brb_status_t;

  // Per-cycle command broadcast from the sequencer to every bank
  typedef struct packed {
    logic              ring_we;
    logic              ring_re;
    logic              flag_we;
    logic              flag_re;
    logic              seg2;      // second run, after the wrap to position zero
    logic [LANE_W-1:0] lane_lo;   // first item lane of the second run
    logic [LANE_W-1:0] lane_cnt;  // bytes in the current run
  } brb_ctl_t;

endpackage

[rtl/brb_bank.sv]
// One storage bank: a slice of the ring and of the flag store, with its lane crossbar.
module brb_bank
  import brb_pkg::*;
#(
  parameter int RING_DEPTH = 4096,
  parameter int FLAG_BYTES = 16,
  parameter int BANK_W     = 3,
  parameter int BANK_IDX   = 0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  brb_ctl_t                      ctl,
  input  logic [$clog2(RING_DEPTH)-1:0] start,
  input  logic [8*DATA_BYTES-1:0]       wdata,
  output logic                          rd_valid,
  output logic [2:0]                    rd_lane,
  output logic [7:0]                    rd_data
);

  localparam int BANKS = 1 << BANK_W;
  localparam int PTR_W = $clog2(RING_DEPTH);
  localparam int RROWS = (RING_DEPTH + BANKS - 1) / BANKS;
  localparam int RR_W  = (RROWS > 1) ? $clog2(RROWS) : 1;
  localparam int FROWS = (FLAG_BYTES + BANKS - 1) / BANKS;
  localparam int FR_W  = (FROWS > 1) ? $clog2(FROWS) : 1;
  localparam logic [BANK_W-1:0] BIDX = BANK_W'(BANK_IDX);

  logic [7:0]        ring_mem [RROWS];
  logic [7:0]        flag_mem [FROWS];
  logic [FROWS-1:0]  fvalid_r;
  logic              rd_valid_r;
  logic [2:0]        rd_lane_r;
  logic [7:0]        rd_data_r;

  logic [BANK_W-1:0] lane1;
  logic [LANE_W-1:0] lane;
  logic              lane_ok;
  logic [PTR_W-1:0]  raddr;
  logic [RR_W-1:0]   rrow;
  logic [4:0]        fsum;
  logic [FR_W-1:0]   frow;
  logic [7:0]        wbyte;

  // Which item lane lands in this bank, and at which row
  always_comb begin
    lane1   = BIDX - start[BANK_W-1:0];
    if (ctl.seg2) begin
      lane    = ctl.lane_lo + LANE_W'(BANK_IDX);
      lane_ok = LANE_W'(BANK_IDX) < ctl.lane_cnt;
      raddr   = PTR_W'(BANK_IDX);
    end else begin
      lane    = LANE_W'(lane1);
      lane_ok = LANE_W'(lane1) < ctl.lane_cnt;
      raddr   = start + PTR_W'(lane1);
    end
    rrow  = RR_W'(raddr >> BANK_W);
    fsum  = 5'(start[3:0]) + 5'(lane1);
    frow  = FR_W'(fsum >> BANK_W);
    wbyte = wdata[8*lane[2:0] +: 8];
  end

  // Ring and flag arrays, read data registered
  always_ff @(posedge clk) begin
    if (ctl.ring_we && lane_ok) begin
      ring_mem[rrow] <= wbyte;
    end
    if (ctl.flag_we && lane_ok) begin
      flag_mem[frow] <= wbyte;
    end
    if (ctl.ring_re && lane_ok) begin
      rd_data_r <= ring_mem[rrow];
    end else if (ctl.flag_re && lane_ok) begin
      rd_data_r <= fvalid_r[frow] ? flag_mem[frow] : 8'h00;
    end
    rd_lane_r <= lane[2:0];
  end

  // Flag entries read as zero until first written; read strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fvalid_r   <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (ctl.flag_we && lane_ok) begin
        fvalid_r[frow] <= 1'b1;
      end
      rd_valid_r <= (ctl.ring_re || ctl.flag_re) && lane_ok;
    end
  end

  assign rd_valid = rd_valid_r;
  assign rd_lane  = rd_lane_r;
  assign rd_data  = rd_data_r;

endmodule

[rtl/brb_merge.sv]
// Merging stage: steers the bytes read by each bank back to their item lanes.
module brb_merge
  import brb_pkg::*;
#(
  parameter int BANKS = 8
) (
  input  logic [BANKS-1:0]          rd_valid,
  input  logic [BANKS-1:0][2:0]     rd_lane,
  input  logic [BANKS-1:0][7:0]     rd_data,
  output logic [8*DATA_BYTES-1:0]   merged
);

  // Each lane collects the byte of the bank that read on its behalf
  always_comb begin
    merged = '0;
    for (int j = 0; j < DATA_BYTES; j++) begin
      for (int b = 0; b < BANKS; b++) begin
        if (rd_valid[b] && (rd_lane[b] == 3'(j))) begin
          merged[8*j +: 8] = merged[8*j +: 8] | rd_data[b];
        end
      end
    end
  end

endmodule

[rtl/byte_ring_buffer_with_flags_core.sv]
// Top level of the byte ring buffer with flag store: sequencer, banks and merge.
//
// A circular byte FIFO with a small flag side store. Each input transfer carries
// an operation (ring write, read, peek, flag write, flag read) and up to eight
// bytes; each produces exactly one result transfer with status, bytes moved, read
// data and the fill level and free space after the operation. The ring is split
// over byte banks addressed by position modulo the bank count, so a run of bytes
// is stored or fetched in one bank access; a run that wraps past the configured
// capacity takes a second bank access. An item steps through decode, a first
// run when bytes move, a second run when a ring access wraps, a capture step for
// a ring or flag read and a done step that loads the result; the single-ported
// banks and their registered read data set these steps. A finished result waits
// in an output register while the next item is taken. No clearing pass runs
// after reset: ring contents are undefined until written, and flag bytes read
// as zero until written.
module byte_ring_buffer_with_flags_core
  import brb_pkg::*;
#(
  parameter int RING_DEPTH = 4096,
  parameter int FLAG_BYTES = 16,
  parameter int LANES      = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // byte_count[3:0], write_data[67:4], flag_position[71:68]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // opcode[2:0]
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // bytes_done[3:0], read_data[67:4], bytes_readable[79:68],
  // bytes_writable[92:80], zero[95:93]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // status[1:0]
  output logic [OUT_TUSER_W-1:0] out_tuser,
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [CFG_W-1:0]       cfg_wdata
);

  localparam int BANK_W  = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int BANKS   = 1 << BANK_W;
  localparam int PTR_W   = $clog2(RING_DEPTH);
  localparam int CAP_W   = $clog2(RING_DEPTH + 1);
  localparam int CMP_W   = (CAP_W > CFG_W) ? CAP_W : CFG_W;
  localparam int CAP_RST = (RING_DEPTH < 4096) ? RING_DEPTH : 4096;
  localparam int FSZ_RST = (FLAG_BYTES < 16) ? FLAG_BYTES : 16;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEC,
    S_SEG1,
    S_SEG2,
    S_CAP,
    S_DONE
  } state_t;

  state_t                 state_r;
  logic [CAP_W-1:0]       cap_r;
  logic [4:0]             fsz_r;
  logic [PTR_W-1:0]       head_r;
  logic [PTR_W-1:0]       tail_r;
  logic [PTR_W-1:0]       fill_r;
  logic [CAP_W-1:0]       free_r;

  // Item held while it is worked on
  logic [2:0]             op_r;
  logic [LANE_W-1:0]      cnt_r;
  logic [8*DATA_BYTES-1:0] wdata_r;
  logic [3:0]             fpos_r;
  logic [8*DATA_BYTES-1:0] rdata_r;

  // Decoded plan of the item
  brb_status_t            st_r;
  logic [LANE_W-1:0]      done_r;
  logic [PTR_W-1:0]       start_r;
  logic [LANE_W-1:0]      len_r;
  logic [LANE_W-1:0]      m_r;
  logic [LANE_W-1:0]      len2_r;
  logic                   wrap_r;
  logic                   ring_wr_r;
  logic                   ring_rd_r;
  logic                   advance_r;
  logic                   flag_wr_r;
  logic                   flag_rd_r;

  logic                   out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;
  logic [OUT_TUSER_W-1:0] out_tuser_r;

  // Decode signals
  logic                   is_wr;
  logic                   is_rd;
  logic                   is_fl;
  logic [LANE_W-1:0]      n_rd;
  logic [PTR_W-1:0]       start_sel;
  logic [CAP_W-1:0]       room;
  logic [LANE_W-1:0]      len_sel;
  logic                   wrap_sel;
  logic [LANE_W-1:0]      m_sel;
  logic                   wr_ok;
  logic                   ferr;
  brb_status_t            st_sel;
  logic [LANE_W-1:0]      done_sel;
  logic                   ring_wr_sel;
  logic                   ring_rd_sel;
  logic                   flag_go;
  logic [LANE_W-1:0]      in_cnt;
  logic [CMP_W-1:0]       cfg_ext;
  logic [CAP_W-1:0]       cap_cfg;
  logic [4:0]             fsz_cfg;
  logic [PTR_W-1:0]       new_ptr;

  brb_ctl_t               ctl;
  logic [BANKS-1:0]       bk_rvalid;
  logic [BANKS-1:0][2:0]  bk_rlane;
  logic [BANKS-1:0][7:0]  bk_rdata;
  logic [8*DATA_BYTES-1:0] merged;

  assign in_tready = rst_n && (state_r == S_IDLE);

  // Byte count held to the lane count
  assign in_cnt = (in_tdata[3:0] > LANE_W'(LANES)) ? LANE_W'(LANES) : in_tdata[3:0];

  // Saturation of the configuration values
  always_comb begin
    cfg_ext = CMP_W'(cfg_wdata);
    if (cfg_ext < CMP_W'(2)) begin
      cap_cfg = CAP_W'(2);
    end else if (cfg_ext > CMP_W'(RING_DEPTH)) begin
      cap_cfg = CAP_W'(RING_DEPTH);
    end else begin
      cap_cfg = CAP_W'(cfg_ext);
    end
    if (9'(cfg_wdata[4:0]) > 9'(FLAG_BYTES)) begin
      fsz_cfg = 5'(FLAG_BYTES);
    end else begin
      fsz_cfg = cfg_wdata[4:0];
    end
  end

  // Item decode: space check, flag range check, byte run and split at the capacity boundary
  always_comb begin
    is_wr     = (op_r == OP_WRITE);
    is_rd     = (op_r == OP_READ) || (op_r == OP_PEEK);
    is_fl     = (op_r == OP_FLAG_WR) || (op_r == OP_FLAG_RD);
    wr_ok     = CAP_W'(cnt_r) < free_r;
    n_rd      = (CAP_W'(cnt_r) < CAP_W'(fill_r)) ? cnt_r : LANE_W'(fill_r);
    start_sel = is_wr ? tail_r : head_r;
    room      = cap_r - CAP_W'(start_sel);
    len_sel   = is_wr ? cnt_r : n_rd;
    wrap_sel  = CAP_W'(len_sel) >= room;
    m_sel     = wrap_sel ? LANE_W'(room) : len_sel;
    ferr      = (5'(fpos_r) + 5'(cnt_r)) > fsz_r;
    new_ptr   = wrap_r ? PTR_W'(len2_r) : start_r + PTR_W'(m_r);

    // Status, bytes moved and the bank work the item needs
    ring_wr_sel = is_wr && wr_ok && (cnt_r != '0);
    ring_rd_sel = is_rd && (n_rd != '0);
    flag_go     = is_fl && !ferr && (cnt_r != '0);
    if (is_wr && !wr_ok) begin
      st_sel = ST_NO_SPACE;
    end else if (is_fl && ferr) begin
      st_sel = ST_RANGE_ERR;
    end else begin
      st_sel = ST_OK;
    end
    if (is_wr) begin
      done_sel = wr_ok ? cnt_r : '0;
    end else if (is_rd) begin
      done_sel = n_rd;
    end else if (is_fl) begin
      done_sel = ferr ? '0 : cnt_r;
    end else begin
      done_sel = '0;
    end
  end

  // Sequencer, pointers, configuration and the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cap_r        <= CAP_W'(CAP_RST);
      fsz_r        <= 5'(FSZ_RST);
      head_r       <= '0;
      tail_r       <= '0;
      fill_r       <= '0;
      free_r       <= CAP_W'(CAP_RST);
      ring_wr_r    <= 1'b0;
      ring_rd_r    <= 1'b0;
      advance_r    <= 1'b0;
      flag_wr_r    <= 1'b0;
      flag_rd_r    <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      // Read data starts empty and gathers bank bytes while an item is worked on
      if (state_r == S_IDLE) begin
        rdata_r <= '0;
      end else begin
        rdata_r <= rdata_r | merged;
      end

      // A taken result frees the output register unless a new one loads
      if (out_tvalid_r && out_tready && (state_r != S_DONE)) begin
        out_tvalid_r <= 1'b0;
      end

      // Register writes must arrive only while the block is idle; the block itself does not enforce this
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_RING_CAP: begin
            cap_r  <= cap_cfg;
            head_r <= '0;
            tail_r <= '0;
            fill_r <= '0;
            free_r <= cap_cfg;
          end
          CFG_FLAG_SIZE: begin
            fsz_r <= fsz_cfg;
          end
          default: ;
        endcase
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            op_r    <= in_tuser;
            cnt_r   <= in_cnt;
            wdata_r <= in_tdata[67:4];
            fpos_r  <= in_tdata[71:68];
            state_r <= S_DEC;
          end
        end
        S_DEC: begin
          st_r      <= st_sel;
          done_r    <= done_sel;
          start_r   <= is_fl ? PTR_W'(fpos_r) : start_sel;
          len_r     <= len_sel;
          m_r       <= is_fl ? cnt_r : m_sel;
          len2_r    <= is_fl ? '0 : len_sel - m_sel;
          wrap_r    <= wrap_sel;
          ring_wr_r <= ring_wr_sel;
          ring_rd_r <= ring_rd_sel;
          advance_r <= ring_rd_sel && (op_r == OP_READ);
          flag_wr_r <= flag_go && (op_r == OP_FLAG_WR);
          flag_rd_r <= flag_go && (op_r == OP_FLAG_RD);
          state_r   <= (ring_wr_sel || ring_rd_sel || flag_go) ? S_SEG1 : S_DONE;
        end
        S_SEG1: begin
          if (ring_wr_r) begin
            tail_r <= new_ptr;
            fill_r <= fill_r + PTR_W'(len_r);
            free_r <= free_r - CAP_W'(len_r);
          end
          if (advance_r) begin
            head_r <= new_ptr;
            fill_r <= fill_r - PTR_W'(len_r);
            free_r <= free_r + CAP_W'(len_r);
          end
          if (len2_r != '0) begin
            state_r <= S_SEG2;
          end else if (ring_rd_r || flag_rd_r) begin
            state_r <= S_CAP;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_SEG2: begin
          state_r <= (ring_rd_r || flag_rd_r) ? S_CAP : S_DONE;
        end
        S_CAP: begin
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_tuser_r  <= st_r;
            out_tdata_r  <= {3'b000, 13'(free_r), 12'(fill_r), rdata_r, done_r};
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Bank command for the current run
  always_comb begin
    ctl.ring_we  = ring_wr_r && ((state_r == S_SEG1) || (state_r == S_SEG2));
    ctl.ring_re  = ring_rd_r && ((state_r == S_SEG1) || (state_r == S_SEG2));
    ctl.flag_we  = flag_wr_r && (state_r == S_SEG1);
    ctl.flag_re  = flag_rd_r && (state_r == S_SEG1);
    ctl.seg2     = (state_r == S_SEG2);
    ctl.lane_lo  = m_r;
    ctl.lane_cnt = (state_r == S_SEG2) ? len2_r : m_r;
  end

  // Storage banks, one per byte position modulo the bank count
  for (genvar b = 0; b < BANKS; b++) begin : g_bank
    brb_bank #(
      .RING_DEPTH (RING_DEPTH),
      .FLAG_BYTES (FLAG_BYTES),
      .BANK_W     (BANK_W),
      .BANK_IDX   (b)
    ) u_bank (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .start    (start_r),
      .wdata    (wdata_r),
      .rd_valid (bk_rvalid[b]),
      .rd_lane  (bk_rlane[b]),
      .rd_data  (bk_rdata[b])
    );
  end

  brb_merge #(
    .BANKS (BANKS)
  ) u_merge (
    .rd_valid (bk_rvalid),
    .rd_lane  (bk_rlane),
    .rd_data  (bk_rdata),
    .merged   (merged)
  );

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

[rtl/brb_checker.sv]
// Port-level checks on the result channel of the byte ring buffer.
module brb_checker
  import brb_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic [OUT_TUSER_W-1:0] out_tuser
);

  // A stalled result holds its contents
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // Only defined status codes are reported
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser != 2'd3))
    else $error("undefined status code");

  // A refused or failed item moves no bytes
  a_fail_none: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != ST_OK) |-> (out_tdata[3:0] == 4'd0) && (out_tdata[67:4] == '0))
    else $error("bytes moved by a refused item");

  // One ring slot always stays empty
  a_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[92:80] != 13'd0))
    else $error("ring reported with no free space");

endmodule

bind byte_ring_buffer_with_flags_core brb_checker u_brb_checker (.*);

[verif/byte_ring_buffer_with_flags_core_tb.sv]
// Self-checking testbench for the byte ring buffer with flag store.
module byte_ring_buffer_with_flags_core_tb;
  import brb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING_DEPTH  = 4096;
  localparam int FLAG_BYTES  = 16;
  localparam int LANES       = 8;
  localparam int SETTLE_CYCS = 10;
  localparam int STALL_LIMIT = 2000;

  // One access as presented on the input channel
  typedef struct packed {
    logic [2:0]  op;
    logic [3:0]  cnt;
    logic [63:0] data;
    logic [3:0]  fpos;
  } access_t;

  // One result as carried on the output channel
  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  done;
    logic [63:0] rdata;
    logic [11:0] readable;
    logic [12:0] writable;
  } outcome_t;

  typedef enum {MIX_BALANCED, MIX_FILL, MIX_TOPUP} mix_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  // byte_count, write_data, flag_position from the lowest bit up
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  // opcode
  logic [IN_TUSER_W-1:0]  in_tuser   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // bytes_done, read_data, bytes_readable, bytes_writable, zero padding
  logic [OUT_TDATA_W-1:0] out_tdata;
  // status
  logic [OUT_TUSER_W-1:0] out_tuser;
  logic                   cfg_we     = 1'b0;
  logic                   cfg_index  = 1'b0;
  logic [CFG_W-1:0]       cfg_wdata  = '0;

  // Stimulus and expectation stores
  access_t  access_q[$];
  outcome_t due_results[$];
  access_t  next_access;
  outcome_t want;
  logic     in_taken    = 1'b0;
  bit       steady_flow = 1'b0;
  int       in_gap      = 0;
  int       out_gap     = 0;
  int       quiet_cycs  = 0;

  // Predictor state
  logic [7:0]  ring_mem [RING_DEPTH];
  logic [7:0]  flag_mem [FLAG_BYTES];
  int unsigned rd_ptr = 0;
  int unsigned wr_ptr = 0;
  logic [12:0] cap_setting  = 13'd4096;
  logic [4:0]  flag_setting = 5'd16;

  // Run statistics
  int mismatches = 0;
  int n_accesses = 0;
  int n_results  = 0;
  int n_settings = 1;
  int n_refused  = 0;
  int n_range    = 0;
  int n_wraps    = 0;
  int peak_fill  = 0;

  byte_ring_buffer_with_flags_core #(
    .RING_DEPTH(RING_DEPTH),
    .FLAG_BYTES(FLAG_BYTES),
    .LANES     (LANES)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Clock generation.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Capacity in use, held within the legal range.
  function automatic int unsigned ring_cap();
    if (cap_setting < 2) return 2;
    if (cap_setting > RING_DEPTH) return RING_DEPTH;
    return cap_setting;
  endfunction

  function automatic int unsigned flags_in_use();
    return (flag_setting > FLAG_BYTES) ? FLAG_BYTES : flag_setting;
  endfunction

  function automatic int unsigned ring_fill(int unsigned cap);
    return (wr_ptr >= rd_ptr) ? wr_ptr - rd_ptr : cap - (rd_ptr - wr_ptr);
  endfunction

  function automatic int unsigned next_pos(int unsigned p, int unsigned cap);
    if (p + 1 >= cap) begin
      n_wraps++;
      return 0;
    end
    return p + 1;
  endfunction

  // Works out the result of one access and updates the predicted state.
  function automatic outcome_t predict_access(access_t a);
    outcome_t    r;
    int unsigned cap, fsz, cnt, fill, n, p;
    r   = '0;
    cap = ring_cap();
    cnt = (a.cnt > LANES) ? LANES : a.cnt;
    if (rd_ptr >= cap) rd_ptr = 0;
    if (wr_ptr >= cap) wr_ptr = 0;
    case (a.op)
      OP_WRITE: begin
        // All or nothing; one slot always stays free.
        if (cnt >= cap - ring_fill(cap)) begin
          r.status = ST_NO_SPACE;
          n_refused++;
        end else begin
          for (int i = 0; i < cnt; i++) begin
            ring_mem[wr_ptr] = a.data[8*i +: 8];
            wr_ptr = next_pos(wr_ptr, cap);
          end
          r.done = 4'(cnt);
        end
      end
      OP_READ, OP_PEEK: begin
        fill = ring_fill(cap);
        n    = (cnt < fill) ? cnt : fill;
        p    = rd_ptr;
        for (int i = 0; i < n; i++) begin
          r.rdata[8*i +: 8] = ring_mem[p];
          p = next_pos(p, cap);
        end
        if (a.op == OP_READ) rd_ptr = p;
        r.done = 4'(n);
      end
      OP_FLAG_WR, OP_FLAG_RD: begin
        fsz = flags_in_use();
        if (a.fpos + cnt > fsz) begin
          r.status = ST_RANGE_ERR;
          n_range++;
        end else begin
          for (int i = 0; i < cnt; i++) begin
            if (a.op == OP_FLAG_WR) flag_mem[(a.fpos + i) % FLAG_BYTES] = a.data[8*i +: 8];
            else r.rdata[8*i +: 8] = flag_mem[(a.fpos + i) % FLAG_BYTES];
          end
          r.done = 4'(cnt);
        end
      end
      default: ;
    endcase
    fill       = ring_fill(cap);
    r.readable = 12'(fill);
    r.writable = 13'(cap - fill);
    if (fill > peak_fill) peak_fill = fill;
    return r;
  endfunction

  // Draws one access; flag accesses mostly stay inside the flag area.
  function automatic access_t random_access(mix_t mix);
    access_t     a;
    int unsigned roll, fsz, room;
    roll   = $urandom_range(0, 99);
    a.data = {$urandom, $urandom};
    a.fpos = 4'($urandom_range(0, 15));
    case ($urandom_range(0, 19))
      0:       a.cnt = 4'd0;
      1:       a.cnt = 4'($urandom_range(LANES + 1, 15));
      default: a.cnt = 4'($urandom_range(1, LANES));
    endcase
    case (mix)
      MIX_FILL: begin
        a.op  = OP_WRITE;
        a.cnt = 4'(LANES);
      end
      MIX_TOPUP: begin
        if (roll < 80) a.op = OP_WRITE;
        else if (roll < 90) a.op = OP_READ;
        else if (roll < 95) a.op = OP_PEEK;
        else a.op = OP_FLAG_RD;
      end
      default: begin
        if (roll < 35) a.op = OP_WRITE;
        else if (roll < 60) a.op = OP_READ;
        else if (roll < 70) a.op = OP_PEEK;
        else if (roll < 82) a.op = OP_FLAG_WR;
        else if (roll < 94) a.op = OP_FLAG_RD;
        else a.op = 3'($urandom_range(OP_FLAG_RD + 1, 7));
      end
    endcase
    if ((a.op == OP_FLAG_WR || a.op == OP_FLAG_RD) && $urandom_range(0, 3) != 0) begin
      fsz    = flags_in_use();
      a.fpos = 4'($urandom_range(0, (fsz > 15) ? 15 : fsz));
      room   = (fsz > a.fpos) ? fsz - a.fpos : 0;
      a.cnt  = 4'($urandom_range(0, (room > LANES) ? LANES : room));
    end
    return a;
  endfunction

  task automatic queue_access(logic [2:0] op, logic [3:0] cnt, logic [63:0] data,
                              logic [3:0] fpos);
    access_q.push_back('{op: op, cnt: cnt, data: data, fpos: fpos});
  endtask

  // Waits until every access has been taken and every result has arrived.
  task automatic settle();
    do @(posedge clk);
    while (access_q.size() != 0 || in_tvalid || due_results.size() != 0);
    repeat (SETTLE_CYCS) @(posedge clk);
  endtask

  // Writes both registers while the block is idle; a capacity write empties the ring.
  task automatic configure(logic [CFG_W-1:0] cap_val, logic [CFG_W-1:0] flag_val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_RING_CAP;
    cfg_wdata <= cap_val;
    cap_setting = cap_val;
    rd_ptr      = 0;
    wr_ptr      = 0;
    @(negedge clk);
    cfg_index <= CFG_FLAG_SIZE;
    cfg_wdata <= flag_val;
    flag_setting = flag_val[4:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  task automatic run_random(int n, mix_t mix);
    repeat (n) access_q.push_back(random_access(mix));
    settle();
  endtask

  task automatic check_field(string name, logic [63:0] expected, logic [63:0] actual);
    if (expected !== actual) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, expected, actual);
      mismatches++;
    end
  endtask

  // Input driver: presents queued accesses at the falling edge, with random gaps.
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_taken)) begin
      if (in_gap != 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (!steady_flow && $urandom_range(0, 11) == 0) begin
        in_gap = $urandom_range(0, 12);
        in_tvalid <= 1'b0;
      end else if (access_q.size() != 0) begin
        next_access = access_q.pop_front();
        in_tdata  <= {next_access.fpos, next_access.data, next_access.cnt};
        in_tuser  <= next_access.op;
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result side back-pressure in random bursts.
  always @(negedge clk) begin
    if (out_gap != 0) begin
      out_gap--;
      out_tready <= 1'b0;
    end else if (!steady_flow && $urandom_range(0, 9) == 0) begin
      out_gap = $urandom_range(0, 12);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Monitor: predicts each accepted access and checks each result transfer.
  always @(posedge clk) begin
    in_taken <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      n_accesses++;
      due_results.push_back(predict_access('{op: in_tuser, cnt: in_tdata[3:0],
                                             data: in_tdata[67:4],
                                             fpos: in_tdata[71:68]}));
    end
    if (rst_n && out_tvalid && out_tready) begin
      n_results++;
      if (due_results.size() == 0) begin
        $error("Result transfer arrived with no expected result waiting");
        mismatches++;
      end else begin
        want = due_results.pop_front();
        check_field("status", want.status, out_tuser[1:0]);
        check_field("bytes_done", want.done, out_tdata[3:0]);
        check_field("read_data", want.rdata, out_tdata[67:4]);
        check_field("bytes_readable", want.readable, out_tdata[79:68]);
        check_field("bytes_writable", want.writable, out_tdata[92:80]);
      end
    end
  end

  // Watchdog on cycles in which no transfer takes place.
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycs = 0;
    end else begin
      quiet_cycs++;
    end
    if (quiet_cycs >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Test sequence.
  initial begin
    for (int i = 0; i < FLAG_BYTES; i++) flag_mem[i] = 8'h00;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed accesses at the reset settings: flags read as zero before any write.
    queue_access(OP_FLAG_RD, 4'd8, 64'h0, 4'd0);
    queue_access(OP_FLAG_RD, 4'd8, 64'h0, 4'd8);
    queue_access(OP_READ, 4'd8, 64'h0, 4'd0);
    queue_access(OP_WRITE, 4'd0, 64'hDEAD_BEEF_0000_0001, 4'd0);
    queue_access(OP_WRITE, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15);
    queue_access(OP_WRITE, 4'd15, 64'h0123_4567_89AB_CDEF, 4'd0);
    queue_access(OP_PEEK, 4'd3, 64'h0, 4'd0);
    queue_access(OP_READ, 4'd0, 64'h0, 4'd0);
    queue_access(OP_READ, 4'd5, 64'h0, 4'd0);
    queue_access(OP_PEEK, 4'd15, 64'h0, 4'd0);
    queue_access(OP_READ, 4'd8, 64'h0, 4'd0);
    queue_access(OP_READ, 4'd8, 64'h0, 4'd0);
    queue_access(OP_FLAG_WR, 4'd8, 64'hA5C3_0F96_5A3C_F069, 4'd0);
    queue_access(OP_FLAG_WR, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8);
    queue_access(OP_FLAG_RD, 4'd1, 64'h0, 4'd15);
    queue_access(OP_FLAG_WR, 4'd2, 64'h1234, 4'd15);
    queue_access(OP_FLAG_RD, 4'd8, 64'h0, 4'd9);
    queue_access(OP_FLAG_WR, 4'd15, 64'h5555_5555_5555_5555, 4'd15);
    queue_access(OP_FLAG_RD, 4'd0, 64'h0, 4'd0);
    queue_access(OP_FLAG_RD, 4'd12, 64'h0, 4'd3);
    queue_access(3'(OP_FLAG_RD + 1), 4'd8, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15);
    queue_access(3'(OP_FLAG_RD + 2), 4'd3, 64'h00FF, 4'd2);
    queue_access(3'(OP_FLAG_RD + 3), 4'd15, 64'h8000_0000_0000_0000, 4'd7);
    settle();

    // Small rings refuse often and wrap constantly; flag sizes swept and saturated.
    configure(13'd2, 13'd0);
    run_random(60, MIX_BALANCED);
    configure(13'd0, 13'd1);
    run_random(40, MIX_BALANCED);
    configure(13'd1, 13'd31);
    run_random(40, MIX_BALANCED);
    configure(13'd9, 13'h0105);
    run_random(150, MIX_BALANCED);
    configure(13'd17, 13'd16);
    run_random(150, MIX_BALANCED);
    configure(13'd100, 13'd17);
    run_random(100, MIX_BALANCED);
    configure(13'd4096, 13'd12);
    run_random(80, MIX_BALANCED);

    // Fill most of the largest ring with full-width writes, then top it up around the full mark.
    configure(13'd8191, 13'd8);
    run_random(500, MIX_FILL);
    run_random(140, MIX_TOPUP);

    // Closing stretch at full rate on both sides.
    steady_flow = 1'b1;
    configure(13'd4097, 13'h0110);
    run_random(100, MIX_BALANCED);

    $display("Checked %0d results from %0d accesses across %0d register settings.",
             n_results, n_accesses, n_settings);
    $display("Peak fill %0d bytes, %0d refused writes, %0d flag range errors, %0d wraps.",
             peak_fill, n_refused, n_range, n_wraps);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/brb_pkg.sv
rtl/brb_bank.sv
rtl/brb_merge.sv
rtl/byte_ring_buffer_with_flags_core.sv
rtl/brb_checker.sv
verif/byte_ring_buffer_with_flags_core_tb.sv
